@@ rtl/core/primitive_index_assembler_assert.svh @@
// ----------------------------------------------------------------------------
// Primitive index assembler assertion macros
// Implication checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_INDEX_ASSEMBLER_ASSERT_SVH
`define PRIMITIVE_INDEX_ASSEMBLER_ASSERT_SVH

// same-cycle implication
`define PIA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("primitive_index_assembler: same-cycle check failed");

// next-cycle implication
`define PIA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("primitive_index_assembler: next-cycle check failed");

`endif

@@ rtl/core/pia_pkg.sv @@
// ----------------------------------------------------------------------------
// Primitive index assembler package
// Shared widths, mode and kind codes, queue entry type and emit patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package pia_pkg;

	localparam int INDEX_WIDTH = 32;
	localparam int IDX_FIELD_W = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int STEP_W      = 3;
	localparam int LEN_W       = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PRIM_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIREFRAME = 2'd1;

	typedef enum logic [2:0] {
		MODE_TRIS,
		MODE_QUADS,
		MODE_STRIP,
		MODE_FAN,
		MODE_POLYGON,
		MODE_LINES,
		MODE_POINTS,
		MODE_PASS
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TRIS,
		KIND_LINES,
		KIND_POINTS
	} kind_t;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		PAT_ONE,
		PAT_TRI,
		PAT_TRI_WIRE,
		PAT_QUAD,
		PAT_QUAD_WIRE
	} pat_t;

	typedef struct packed {
		logic [3:0][INDEX_WIDTH-1:0] idx;
		pat_t                        pat;
		kind_t                       kind;
	} pia_job_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} pia_q_status_t;

	localparam logic [0:7][1:0] SEL_TRI       = {2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
	localparam logic [0:7][1:0] SEL_TRI_WIRE  = {2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0};
	localparam logic [0:7][1:0] SEL_QUAD      = {2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3, 2'd0, 2'd0};
	localparam logic [0:7][1:0] SEL_QUAD_WIRE = {2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};

	function automatic logic [LEN_W-1:0] pat_len(pat_t p);
		logic [LEN_W-1:0] n;
		unique case (p)
			PAT_ONE:       n = 4'd1;
			PAT_TRI:       n = 4'd3;
			PAT_TRI_WIRE:  n = 4'd6;
			PAT_QUAD:      n = 4'd6;
			PAT_QUAD_WIRE: n = 4'd8;
			default:       n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [1:0] pat_sel(pat_t p, logic [STEP_W-1:0] s);
		logic [1:0] r;
		unique case (p)
			PAT_ONE:       r = 2'd0;
			PAT_TRI:       r = SEL_TRI[s];
			PAT_TRI_WIRE:  r = SEL_TRI_WIRE[s];
			PAT_QUAD:      r = SEL_QUAD[s];
			PAT_QUAD_WIRE: r = SEL_QUAD_WIRE[s];
			default:       r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/pia_if.sv @@
// ----------------------------------------------------------------------------
// Primitive index assembler channels
// Valid/ready channels for configuration, vertex input and index output.
// ----------------------------------------------------------------------------
`default_nettype none

interface pia_cfg_if;
	import pia_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

interface pia_vtx_if;
	import pia_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [IDX_FIELD_W-1:0] vertex_index;
	logic                   end_of_draw;
	modport source (output valid, output vertex_index, output end_of_draw, input ready);
	modport sink (input valid, input vertex_index, input end_of_draw, output ready);
endinterface

interface pia_idx_if;
	import pia_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [IDX_FIELD_W-1:0] out_index;
	logic [1:0]             draw_kind;
	logic                   last_in_run;
	modport source (output valid, output out_index, output draw_kind, output last_in_run,
		input ready);
	modport sink (input valid, input out_index, input draw_kind, input last_in_run,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/primitive_index_assembler.sv @@
// ----------------------------------------------------------------------------
// Primitive index assembler
// Turns a vertex index stream into triangle, edge, line or point index lists.
// ----------------------------------------------------------------------------
//   channel  dir  payload                                   handshake
//   cfg      in   reg_index[1:0], wdata[2:0]                valid/ready
//   vtx      in   vertex_index[31:0], end_of_draw           valid/ready
//   idx      out  out_index[31:0], draw_kind[1:0], last_in_run  valid/ready
//
// A vertex is taken every cycle while the two-entry job queue has room.
// The emit stage gives one index per cycle while idx is ready: 1 per vertex for
// lines, points and passthrough, 3 or 6 per triangle, 6 or 8 per quad, so output
// bandwidth sets the sustained rate. Results pass the queue, job and output regs.
// Reset clears configuration, assembly state, queue, job state and output valid.
// Either side may stall; the queue and the output register absorb it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "primitive_index_assembler_assert.svh"

module primitive_index_assembler (
	input  logic       clk,
	input  logic       arst_n,
	pia_cfg_if.sink    cfg,
	pia_vtx_if.sink    vtx,
	pia_idx_if.source  idx
);
	import pia_pkg::*;

	logic          q_push;
	logic          q_pop;
	pia_job_t      push_job;
	pia_job_t      pop_job;
	pia_q_status_t q_status;

	pia_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.vtx      (vtx),
		.q_status (q_status),
		.push     (q_push),
		.push_job (push_job)
	);

	pia_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.status   (q_status)
	);

	pia_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_job    (pop_job),
		.pop      (q_pop),
		.idx      (idx)
	);

	`PIA_ASSERT_IMP(a_full_stall, q_status.full, !vtx.ready)
	`PIA_ASSERT_IMP(a_kind_legal, idx.valid, idx.draw_kind != KIND_UNUSED)
	`PIA_ASSERT_IMP(a_count_bound, 1'b1, q_status.count <= QCNT_W'(QUEUE_DEPTH))
	`PIA_ASSERT_NXT(a_fill, q_push && !q_pop && q_status.count == QCNT_W'(QUEUE_DEPTH - 1), q_status.full)

endmodule

`default_nettype wire

@@ rtl/core/pia_queue.sv @@
// ----------------------------------------------------------------------------
// Primitive index assembler job queue
// Short register queue between the assembly front and the emit back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pia_pkg::pia_job_t      push_job,
	input  logic                   pop,
	output pia_pkg::pia_job_t      pop_job,
	output pia_pkg::pia_q_status_t status
);
	import pia_pkg::*;

	pia_job_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_job      = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pia_front.sv @@
// ----------------------------------------------------------------------------
// Primitive index assembler front end
// Holds configuration and assembly state, turns vertices into emit jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_front (
	input  logic                   clk,
	input  logic                   arst_n,
	pia_cfg_if.sink                cfg,
	pia_vtx_if.sink                vtx,
	input  pia_pkg::pia_q_status_t q_status,
	output logic                   push,
	output pia_pkg::pia_job_t      push_job
);
	import pia_pkg::*;

	mode_t                  mode_q;
	logic                   wire_q;
	logic [INDEX_WIDTH-1:0] held0_q;
	logic [INDEX_WIDTH-1:0] held1_q;
	logic [INDEX_WIDTH-1:0] held2_q;
	logic [INDEX_WIDTH-1:0] fan_first_q;
	logic [1:0]             phase_q;
	logic [1:0]             seen_q;
	logic                   odd_q;

	logic [INDEX_WIDTH-1:0] held0_d;
	logic [INDEX_WIDTH-1:0] held1_d;
	logic [INDEX_WIDTH-1:0] held2_d;
	logic [INDEX_WIDTH-1:0] fan_first_d;
	logic [1:0]             phase_d;
	logic [1:0]             seen_d;
	logic                   odd_d;

	logic                   accept;
	logic                   cfg_wr;
	logic                   emit;
	logic [INDEX_WIDTH-1:0] v;
	kind_t                  fill_kind;

	assign cfg.ready = 1'b1;
	assign vtx.ready = !q_status.full;
	assign accept    = vtx.valid && vtx.ready;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign v         = vtx.vertex_index[INDEX_WIDTH-1:0];
	assign fill_kind = wire_q ? KIND_LINES : KIND_TRIS;
	assign push      = accept && emit;

	always_comb begin
		held0_d         = held0_q;
		held1_d         = held1_q;
		held2_d         = held2_q;
		fan_first_d     = fan_first_q;
		phase_d         = phase_q;
		seen_d          = seen_q;
		odd_d           = odd_q;
		emit            = 1'b0;
		push_job.idx[0] = v;
		push_job.idx[1] = held1_q;
		push_job.idx[2] = v;
		push_job.idx[3] = v;
		push_job.pat    = PAT_ONE;
		push_job.kind   = fill_kind;
		unique case (mode_q)
			MODE_TRIS: begin
				if (phase_q >= 2'd2) begin
					emit            = 1'b1;
					push_job.idx[0] = held0_q;
					push_job.pat    = wire_q ? PAT_TRI_WIRE : PAT_TRI;
					phase_d         = 2'd0;
				end else begin
					if (phase_q == 2'd0) begin
						held0_d = v;
					end else begin
						held1_d = v;
					end
					phase_d = phase_q + 1'b1;
				end
			end
			MODE_QUADS: begin
				if (phase_q == 2'd3) begin
					emit            = 1'b1;
					push_job.idx[0] = held0_q;
					push_job.idx[2] = held2_q;
					push_job.pat    = wire_q ? PAT_QUAD_WIRE : PAT_QUAD;
					phase_d         = 2'd0;
				end else begin
					unique case (phase_q)
						2'd0:    held0_d = v;
						2'd1:    held1_d = v;
						default: held2_d = v;
					endcase
					phase_d = phase_q + 1'b1;
				end
			end
			MODE_STRIP: begin
				if (seen_q >= 2'd2) begin
					emit            = 1'b1;
					push_job.idx[0] = odd_q ? held1_q : held0_q;
					push_job.idx[1] = odd_q ? held0_q : held1_q;
					push_job.pat    = wire_q ? PAT_TRI_WIRE : PAT_TRI;
					odd_d           = !odd_q;
					held0_d         = held1_q;
					held1_d         = v;
				end else begin
					if (seen_q == 2'd0) begin
						held0_d = v;
					end else begin
						held1_d = v;
					end
					seen_d = seen_q + 1'b1;
				end
			end
			MODE_FAN, MODE_POLYGON: begin
				if (seen_q == 2'd0) begin
					fan_first_d = v;
					seen_d      = 2'd1;
				end else if (seen_q == 2'd1) begin
					held0_d = v;
					seen_d  = 2'd2;
				end else begin
					emit            = 1'b1;
					push_job.idx[0] = fan_first_q;
					push_job.idx[1] = held0_q;
					push_job.pat    = wire_q ? PAT_TRI_WIRE : PAT_TRI;
					held0_d         = v;
				end
			end
			MODE_LINES: begin
				emit          = 1'b1;
				push_job.kind = KIND_LINES;
			end
			MODE_POINTS: begin
				emit          = 1'b1;
				push_job.kind = KIND_POINTS;
			end
			MODE_PASS: begin
				emit = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_TRIS;
			wire_q      <= 1'b0;
			held0_q     <= '0;
			held1_q     <= '0;
			held2_q     <= '0;
			fan_first_q <= '0;
			phase_q     <= '0;
			seen_q      <= '0;
			odd_q       <= 1'b0;
		end else if (cfg_wr) begin
			if (cfg.reg_index == REG_PRIM_MODE) begin
				mode_q <= mode_t'(cfg.wdata[2:0]);
			end
			if (cfg.reg_index == REG_WIREFRAME) begin
				wire_q <= cfg.wdata[0];
			end
			if (cfg.reg_index == REG_PRIM_MODE || cfg.reg_index == REG_WIREFRAME) begin
				held0_q     <= '0;
				held1_q     <= '0;
				held2_q     <= '0;
				fan_first_q <= '0;
				phase_q     <= '0;
				seen_q      <= '0;
				odd_q       <= 1'b0;
			end
		end else if (accept) begin
			if (vtx.end_of_draw) begin
				held0_q     <= '0;
				held1_q     <= '0;
				held2_q     <= '0;
				fan_first_q <= '0;
				phase_q     <= '0;
				seen_q      <= '0;
				odd_q       <= 1'b0;
			end else begin
				held0_q     <= held0_d;
				held1_q     <= held1_d;
				held2_q     <= held2_d;
				fan_first_q <= fan_first_d;
				phase_q     <= phase_d;
				seen_q      <= seen_d;
				odd_q       <= odd_d;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pia_back.sv @@
// ----------------------------------------------------------------------------
// Primitive index assembler back end
// Walks each job's emit pattern, one index per transfer, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pia_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pia_pkg::pia_q_status_t q_status,
	input  pia_pkg::pia_job_t      q_job,
	output logic                   pop,
	pia_idx_if.source              idx
);
	import pia_pkg::*;

	pia_job_t               job_q;
	logic                   job_valid_q;
	logic [STEP_W-1:0]      step_q;
	logic                   out_valid_q;
	logic [IDX_FIELD_W-1:0] out_index_q;
	logic [1:0]             out_kind_q;
	logic                   out_last_q;

	logic                   advance;
	logic                   last_step;
	logic [1:0]             sel;

	assign advance   = job_valid_q && (!out_valid_q || idx.ready);
	assign last_step = ({1'b0, step_q} == (pat_len(job_q.pat) - 1'b1));
	assign pop       = !q_status.empty && (!job_valid_q || (advance && last_step));
	assign sel       = pat_sel(job_q.pat, step_q);

	assign idx.valid       = out_valid_q;
	assign idx.out_index   = out_index_q;
	assign idx.draw_kind   = out_kind_q;
	assign idx.last_in_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (advance && last_step) begin
				job_valid_q <= 1'b0;
			end else if (advance) begin
				step_q <= step_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (idx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (advance) begin
			out_index_q <= IDX_FIELD_W'(job_q.idx[sel]);
			out_kind_q  <= job_q.kind;
			out_last_q  <= last_step;
		end
	end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Primitive index assembler testbench
// Feeds vertex index streams under every primitive mode, with and without
// wireframe, through randomly stalled channels. Each accepted vertex updates a
// local assembly model whose emitted indices are checked, in order, against
// the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pia_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
	localparam logic [63:0] INDEX_MASK = (64'd1 << INDEX_WIDTH) - 64'd1;
	localparam int unsigned TARGET_VERTICES = 270;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned DRAIN_LIMIT = 5000;
	localparam int unsigned HOLD_AFTER = 120;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned SCRIPT_ROWS = 40;

	typedef struct packed {
		logic [IDX_FIELD_W-1:0] index;
		kind_t                  kind;
		logic                   last;
	} index_beat_t;

	typedef struct packed {
		bit                     is_write;
		logic [CFG_IDX_W-1:0]   reg_index;
		logic [CFG_DATA_W-1:0]  wdata;
		logic [IDX_FIELD_W-1:0] vertex;
		logic                   eod;
		bit                     typed;
		logic [IDX_FIELD_W-1:0] exp_index;
		kind_t                  exp_kind;
	} script_row_t;

	logic clk;
	logic arst_n;

	pia_cfg_if cfg_bus ();
	pia_vtx_if vtx_bus ();
	pia_idx_if idx_bus ();

	primitive_index_assembler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.vtx    (vtx_bus),
		.idx    (idx_bus)
	);

	// assembly model state
	mode_t       asm_mode;
	logic        asm_wire;
	logic [31:0] held_index [0:2];
	logic [31:0] fan_root;
	logic [1:0]  tri_phase;
	logic [1:0]  run_count;
	logic        strip_flip;

	index_beat_t pending_indices [$];
	int unsigned vertices_accepted;
	int unsigned indices_checked;
	int unsigned register_writes;
	int unsigned errors;
	bit [15:0]   mode_wire_seen;
	bit          long_hold_done;

	script_row_t directed_script [SCRIPT_ROWS] = '{
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd60, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd61, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_SPARE2, 3'b101, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd62, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd63, 1'b1, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_PRIM_MODE, MODE_POINTS, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, KIND_POINTS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, KIND_POINTS},
		'{1'b1, REG_PRIM_MODE, MODE_LINES, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'hA5A5_A5A5, 1'b0, 1'b1, 32'hA5A5_A5A5, KIND_LINES},
		'{1'b1, REG_PRIM_MODE, MODE_PASS, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'h5A5A_5A5A, 1'b0, 1'b1, 32'h5A5A_5A5A, KIND_TRIS},
		'{1'b1, REG_WIREFRAME, 3'b111, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'h0000_FFFF, 1'b0, 1'b1, 32'h0000_FFFF, KIND_LINES},
		'{1'b1, REG_PRIM_MODE, MODE_QUADS, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd10, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd11, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd12, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd13, 1'b1, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_WIREFRAME, 3'b110, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'hFFFF_0000, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd21, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd22, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd23, 1'b1, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_PRIM_MODE, MODE_STRIP, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd30, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd31, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd32, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd33, 1'b1, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_PRIM_MODE, MODE_FAN, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd40, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd41, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd42, 1'b1, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_PRIM_MODE, MODE_POLYGON, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd50, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_WIREFRAME, 3'b000, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd52, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd53, 1'b0, 1'b0, 32'd0, KIND_TRIS},
		'{1'b0, REG_PRIM_MODE, 3'd0, 32'd54, 1'b1, 1'b0, 32'd0, KIND_TRIS},
		'{1'b1, REG_SPARE3, 3'b011, 32'd0, 1'b0, 1'b0, 32'd0, KIND_TRIS}
	};

	function automatic void drop_partial_primitive();
		held_index = '{default: '0};
		fan_root   = '0;
		tri_phase  = '0;
		run_count  = '0;
		strip_flip = 1'b0;
	endfunction

	function automatic void put_index(input logic [31:0] index, input kind_t kind,
		ref index_beat_t beats [$]);
		if (beats.size() < 8)
			beats.insert(beats.size(), index_beat_t'{index, kind, 1'b0});
	endfunction

	function automatic void put_triangle(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input kind_t kind, ref index_beat_t beats [$]);
		if (asm_wire) begin
			put_index(a, kind, beats);
			put_index(b, kind, beats);
			put_index(b, kind, beats);
			put_index(c, kind, beats);
			put_index(c, kind, beats);
			put_index(a, kind, beats);
		end else begin
			put_index(a, kind, beats);
			put_index(b, kind, beats);
			put_index(c, kind, beats);
		end
	endfunction

	function automatic void assemble_vertex(input logic [31:0] vertex, input logic eod,
		ref index_beat_t beats [$]);
		logic [31:0] v;
		logic [31:0] corner [0:3];
		kind_t       kind;
		v = 32'({32'd0, vertex} & INDEX_MASK);
		kind = asm_wire ? KIND_LINES : KIND_TRIS;
		case (asm_mode)
			MODE_TRIS: begin
				if (tri_phase >= 2'd2) begin
					put_triangle(held_index[0], held_index[1], v, kind, beats);
					tri_phase = '0;
				end else begin
					held_index[tri_phase] = v;
					tri_phase++;
				end
			end
			MODE_QUADS: begin
				if (tri_phase >= 2'd3) begin
					corner = '{held_index[0], held_index[1], held_index[2], v};
					if (asm_wire) begin
						for (int e = 0; e < 4; e++) begin
							put_index(corner[e], kind, beats);
							put_index(corner[(e + 1) % 4], kind, beats);
						end
					end else begin
						put_triangle(corner[0], corner[1], corner[2], kind, beats);
						put_triangle(corner[0], corner[2], corner[3], kind, beats);
					end
					tri_phase = '0;
				end else begin
					held_index[tri_phase] = v;
					tri_phase++;
				end
			end
			MODE_STRIP: begin
				if (run_count >= 2'd2) begin
					if (strip_flip)
						put_triangle(held_index[1], held_index[0], v, kind, beats);
					else
						put_triangle(held_index[0], held_index[1], v, kind, beats);
					strip_flip = ~strip_flip;
					held_index[0] = held_index[1];
					held_index[1] = v;
				end else begin
					held_index[run_count] = v;
					run_count++;
				end
			end
			MODE_FAN, MODE_POLYGON: begin
				if (run_count == 2'd0) begin
					fan_root = v;
					run_count = 2'd1;
				end else if (run_count == 2'd1) begin
					held_index[0] = v;
					run_count = 2'd2;
				end else begin
					put_triangle(fan_root, held_index[0], v, kind, beats);
					held_index[0] = v;
				end
			end
			MODE_LINES:  put_index(v, KIND_LINES, beats);
			MODE_POINTS: put_index(v, KIND_POINTS, beats);
			default:     put_index(v, kind, beats);
		endcase
		if (beats.size() > 0)
			beats[beats.size() - 1].last = 1'b1;
		if (eod)
			drop_partial_primitive();
	endfunction

	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int unsigned draw_length(input mode_t mode);
		if ($urandom_range(9) < 2)
			return $urandom_range(1, 7);
		case (mode)
			MODE_TRIS:                         return 3 * $urandom_range(1, 3);
			MODE_QUADS:                        return 4 * $urandom_range(1, 2);
			MODE_STRIP, MODE_FAN, MODE_POLYGON: return $urandom_range(3, 8);
			default:                           return $urandom_range(1, 6);
		endcase
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid     <= 1'b1;
		cfg_bus.reg_index <= index;
		cfg_bus.wdata     <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		if (index == REG_PRIM_MODE) begin
			asm_mode = mode_t'(data);
			drop_partial_primitive();
		end else if (index == REG_WIREFRAME) begin
			asm_wire = data[0];
			drop_partial_primitive();
		end
		register_writes++;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_vertex(input logic [31:0] vertex, input logic eod,
		input int unsigned gap, input bit typed, input logic [31:0] typed_index,
		input kind_t typed_kind);
		index_beat_t beats [$];
		@(negedge clk);
		if (gap > 0) begin
			vtx_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vtx_bus.valid        <= 1'b1;
		vtx_bus.vertex_index <= vertex;
		vtx_bus.end_of_draw  <= eod;
		do @(posedge clk); while (!vtx_bus.ready);
		vertices_accepted++;
		mode_wire_seen[{asm_wire, asm_mode}] = 1'b1;
		assemble_vertex(vertex, eod, beats);
		if (typed) begin
			beats.delete();
			beats.insert(0, index_beat_t'{typed_index, typed_kind, 1'b1});
		end
		foreach (beats[i])
			pending_indices.insert(pending_indices.size(), beats[i]);
	endtask

	// drop valid, then wait for every outstanding index
	task automatic drain(input int unsigned settle);
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		vtx_bus.valid <= 1'b0;
		while (pending_indices.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_indices.size() != 0) begin
			$display("%0t: %0d expected indices never arrived", $time,
				pending_indices.size());
			errors += pending_indices.size();
			pending_indices.delete();
		end
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("%0t: timeout", $time);
		$display("FAIL primitive_index_assembler");
		$finish;
	end

	// output side: short stalls mostly, long ones rarely, one forced hold-off
	initial begin
		int unsigned run_left;
		int unsigned stall_left;
		run_left = 0;
		stall_left = 0;
		idx_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && vertices_accepted >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				idx_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (stall_left > 0) begin
				idx_bus.ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				idx_bus.ready <= 1'b1;
				run_left--;
			end else begin
				idx_bus.ready <= 1'b1;
				run_left = ($urandom_range(9) == 0) ? $urandom_range(40, 120)
					: $urandom_range(0, 7);
				stall_left = ($urandom_range(3) == 0) ? 0 : gap_cycles();
			end
		end
	end

	always @(posedge clk) begin
		index_beat_t want;
		if (arst_n && idx_bus.valid && idx_bus.ready) begin
			if (pending_indices.size() == 0) begin
				$display("%0t: unexpected transfer index %h kind %0d last %b", $time,
					idx_bus.out_index, idx_bus.draw_kind, idx_bus.last_in_run);
				errors++;
			end else begin
				want = pending_indices.pop_front();
				indices_checked++;
				if (idx_bus.out_index !== want.index) begin
					$display("%0t: out_index expected %h actual %h", $time, want.index,
						idx_bus.out_index);
					errors++;
				end
				if (idx_bus.draw_kind !== want.kind) begin
					$display("%0t: draw_kind expected %0d actual %0d", $time, want.kind,
						idx_bus.draw_kind);
					errors++;
				end
				if (idx_bus.last_in_run !== want.last) begin
					$display("%0t: last_in_run expected %b actual %b", $time, want.last,
						idx_bus.last_in_run);
					errors++;
				end
			end
		end
	end

	initial begin
		int unsigned phase_no;
		int unsigned phase_len;
		int unsigned phase_sent;
		int unsigned len;
		int unsigned style;
		logic [31:0] base;
		logic [31:0] vertex;
		logic        eod;
		mode_t       mode;
		logic        wire_on;
		bit          burst;
		bit          paused;

		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.reg_index = '0;
		cfg_bus.wdata = '0;
		vtx_bus.valid = 1'b0;
		vtx_bus.vertex_index = '0;
		vtx_bus.end_of_draw = 1'b0;
		asm_mode = MODE_TRIS;
		asm_wire = 1'b0;
		drop_partial_primitive();
		vertices_accepted = 0;
		indices_checked = 0;
		register_writes = 0;
		errors = 0;
		mode_wire_seen = '0;
		long_hold_done = 1'b0;
		paused = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_script[i]) begin
			if (directed_script[i].is_write) begin
				drain(SETTLE_CYCLES);
				write_register(directed_script[i].reg_index, directed_script[i].wdata);
			end else begin
				send_vertex(directed_script[i].vertex, directed_script[i].eod, gap_cycles(),
					directed_script[i].typed, directed_script[i].exp_index,
					directed_script[i].exp_kind);
			end
		end
		drain(SETTLE_CYCLES);

		phase_no = 0;
		while (vertices_accepted < TARGET_VERTICES) begin
			if (phase_no < 16) begin
				mode = mode_t'(phase_no % 8);
				wire_on = (phase_no >= 8);
			end else begin
				mode = mode_t'($urandom_range(7));
				wire_on = 1'($urandom_range(1));
			end
			if ($urandom_range(1)) begin
				write_register(REG_PRIM_MODE, CFG_DATA_W'(mode));
				write_register(REG_WIREFRAME, {2'($urandom_range(3)), wire_on});
			end else begin
				write_register(REG_WIREFRAME, {2'($urandom_range(3)), wire_on});
				write_register(REG_PRIM_MODE, CFG_DATA_W'(mode));
			end
			if ($urandom_range(4) == 0)
				write_register($urandom_range(1) ? REG_SPARE2 : REG_SPARE3,
					CFG_DATA_W'($urandom_range(7)));

			burst = ($urandom_range(3) == 0);
			phase_len = $urandom_range(10, 18);
			phase_sent = 0;
			while (phase_sent < phase_len) begin
				len = draw_length(mode);
				style = $urandom_range(2);
				base = $urandom;
				for (int unsigned k = 0; k < len; k++) begin
					case (style)
						0:       vertex = k;
						1:       vertex = base + k;
						default: vertex = $urandom;
					endcase
					eod = (k == len - 1) || ($urandom_range(24) == 0);
					send_vertex(vertex, eod, burst ? 0 : gap_cycles(), 1'b0, '0, KIND_TRIS);
					phase_sent++;
				end
				// hold the input back once until the output has caught up
				if (!paused && phase_no == 5) begin
					paused = 1'b1;
					drain(0);
				end
			end
			drain(SETTLE_CYCLES);
			phase_no++;
		end

		drain(SETTLE_CYCLES * 2);

		$display("Sent %0d vertices in %0d random phases, %0d register writes.",
			vertices_accepted, phase_no, register_writes);
		$display("Checked %0d output indices across %0d of 16 mode and wireframe pairs.",
			indices_checked, $countones(mode_wire_seen));
		if (errors == 0)
			$display("PASS primitive_index_assembler");
		else
			$display("FAIL primitive_index_assembler");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/pia_pkg.sv
rtl/core/pia_if.sv
rtl/core/pia_queue.sv
rtl/core/pia_front.sv
rtl/core/pia_back.sv
rtl/core/primitive_index_assembler.sv
tb/testbench.sv
